/* design/psu_pkg.sv */
// Shared types, constants and helpers for the particle pose statistics unit.
// No dependencies; imported by psu_cordic, psu_divider and the top level.
package psu_pkg;

    localparam int PARTICLE_CAP_DEF = 256;
    localparam int CORDIC_STEPS_DEF = 16;

    // Stored particle word: x, y, z (32 bit) then roll, pitch, yaw (19 bit)
    localparam int LIN_W   = 32;
    localparam int ANG_W   = 19;
    localparam int WGT_W   = 17;
    localparam int MW      = 3 * LIN_W + 3 * ANG_W;
    localparam int IN_W    = MW + WGT_W;
    localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 64;
    localparam int OUT_W   = IDX_W + VAL_W;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;
    localparam int SUM_W   = 64;

    localparam int NUM_LIN     = 3;
    localparam int NUM_MEANS   = 6;
    localparam int NUM_RESULTS = 42;

    // Multiplier operand width: a coordinate minus a mean fits in 34 bits
    localparam int MUL_W   = 34;
    localparam int CW      = 66;
    localparam int ZW      = 24;

    localparam int Q_PI        = 205887;
    localparam int Q_HALF_PI   = 102944;
    localparam int CORDIC_GAIN = 39797;

    localparam logic [2:0] C_X     = 3'd0;
    localparam logic [2:0] C_Y     = 3'd1;
    localparam logic [2:0] C_Z     = 3'd2;
    localparam logic [2:0] C_ROLL  = 3'd3;
    localparam logic [2:0] C_PITCH = 3'd4;
    localparam logic [2:0] C_YAW   = 3'd5;

    typedef struct packed {
        logic start;
        logic vector;
    } t_cordic_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    // Arctangent of 2^-i in Q16.16, rounded to nearest
    function automatic logic [16:0] psu_arctan(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Pull one coordinate out of a stored word, sign extended
    function automatic logic signed [MUL_W-1:0] psu_coord(input logic [MW-1:0] word,
                                                          input logic [2:0] sel);
        logic signed [MUL_W-1:0] v;
        unique case (sel)
            C_X:     v = MUL_W'($signed(word[LIN_W-1:0]));
            C_Y:     v = MUL_W'($signed(word[2*LIN_W-1:LIN_W]));
            C_Z:     v = MUL_W'($signed(word[3*LIN_W-1:2*LIN_W]));
            C_ROLL:  v = MUL_W'($signed(word[3*LIN_W+ANG_W-1:3*LIN_W]));
            C_PITCH: v = MUL_W'($signed(word[3*LIN_W+2*ANG_W-1:3*LIN_W+ANG_W]));
            C_YAW:   v = MUL_W'($signed(word[3*LIN_W+3*ANG_W-1:3*LIN_W+2*ANG_W]));
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/psu_cordic.sv */
// Iterative CORDIC: rotation mode for sin/cos, vectoring mode for atan2.
// One micro-rotation per cycle; uses psu_pkg for widths and the arctangent table.
module psu_cordic #(
    parameter int STEPS = psu_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psu_pkg::t_cordic_req            i_req,
    input  logic signed [psu_pkg::CW-1:0]   i_x,
    input  logic signed [psu_pkg::CW-1:0]   i_y,
    input  logic signed [psu_pkg::ZW-1:0]   i_z,
    output psu_pkg::t_unit_status           o_status,
    output logic signed [psu_pkg::CW-1:0]   o_x,
    output logic signed [psu_pkg::CW-1:0]   o_y,
    output logic signed [psu_pkg::ZW-1:0]   o_z
);
    import psu_pkg::*;

    localparam int SW = $clog2(STEPS);

    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [SW-1:0]        r_cnt, n_cnt;
    logic                 r_run, n_run, r_done, n_done;
    logic                 r_vec, n_vec, r_neg, n_neg, r_zero, n_zero;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    logic                 pos;

    assign dx  = r_y >>> r_cnt;
    assign dy  = r_x >>> r_cnt;
    assign at  = ZW'(psu_arctan(5'(r_cnt)));
    assign pos = r_vec ? (r_y <= 0) : (r_z >= 0);

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_cnt = r_cnt;
        n_run = r_run; n_done = 1'b0;
        n_vec = r_vec; n_neg = r_neg; n_zero = r_zero;
        if (i_req.start) begin
            n_vec  = i_req.vector;
            n_cnt  = '0;
            n_neg  = 1'b0;
            n_zero = 1'b0;
            if (i_req.vector) begin
                n_x = i_x; n_y = i_y; n_z = '0;
                if (i_x == 0 && i_y == 0) begin
                    n_zero = 1'b1;
                end else if (i_x < 0) begin
                    // turn a left half-plane vector by 90 degrees first
                    if (i_y >= 0) begin
                        n_x = i_y; n_y = -i_x; n_z = ZW'(Q_HALF_PI);
                    end else begin
                        n_x = -i_y; n_y = i_x; n_z = -ZW'(Q_HALF_PI);
                    end
                end
            end else begin
                n_x = CW'(CORDIC_GAIN); n_y = '0; n_z = i_z;
                if (i_z > ZW'(Q_HALF_PI)) begin
                    n_z = i_z - ZW'(Q_PI); n_neg = 1'b1;
                end else if (i_z < -ZW'(Q_HALF_PI)) begin
                    n_z = i_z + ZW'(Q_PI); n_neg = 1'b1;
                end
            end
            n_run  = !n_zero;
            n_done = n_zero;
        end else if (r_run) begin
            if (pos) begin
                n_x = r_x - dx; n_y = r_y + dy; n_z = r_z - at;
            end else begin
                n_x = r_x + dx; n_y = r_y - dy; n_z = r_z + at;
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SW'(STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_cnt <= n_cnt;
        r_vec <= n_vec; r_neg <= n_neg; r_zero <= n_zero;
    end

    assign o_x = r_neg ? -r_x : r_x;
    assign o_y = r_neg ? -r_y : r_y;
    assign o_z = r_zero ? '0 : r_z;
    assign o_status.busy = r_run;
    assign o_status.done = r_done;

endmodule

/* design/psu_divider.sv */
// Unsigned restoring divider, one quotient bit per cycle.
// Uses psu_pkg for the status struct.
module psu_divider #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output psu_pkg::t_unit_status o_status,
    output logic [NUM_W-1:0]      o_quot
);
    import psu_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem, rem_sh, rem_sub;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run, r_done;
    logic             take;

    assign rem_sh  = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign take    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == CNT_W'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_run) begin
            r_q   <= {r_q[NUM_W-2:0], take};
            r_rem <= take ? rem_sub : rem_sh;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quot = r_q;
    assign o_status.busy = r_run;
    assign o_status.done = r_done;

endmodule

/* design/particle_pose_statistics_unit.sv */
// Particle pose statistics: emits weighted position sums, mean angles and 6x6 covariance.
// Depends on psu_pkg, psu_cordic and psu_divider.
//
// Each particle holds s_axis_tready low while it is folded in: the linear weighted sums go
// through one shared 34x34 multiplier and each angle runs through the single iterative
// CORDIC unit. A word with tlast set starts emission of 42 result words: six atan2 runs,
// three linear-mean divisions, then per covariance entry a pass over the N stored
// particles (one particle memory read per cycle) followed by one serial division; with
// fewer than two particles the divisions and passes are skipped and the covariance
// words are zero. Each result waits in the output register until taken.
// The particle memory is not cleared after reset; only entries of the current set are read.
module particle_pose_statistics_unit #(
    parameter int PARTICLE_CAP = psu_pkg::PARTICLE_CAP_DEF,
    parameter int CORDIC_STEPS = psu_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle, weight, zero pad
    input  logic [psu_pkg::IN_TW-1:0]   s_axis_tdata,
    input  logic                        s_axis_tlast,    // final_particle
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // result_index, result_value, zero pad
    output logic [psu_pkg::OUT_TW-1:0]  m_axis_tdata,
    output logic                        m_axis_tuser,    // capacity_exceeded
    output logic                        m_axis_tlast     // final_result
);
    import psu_pkg::*;

    localparam int ADDR_W = $clog2(PARTICLE_CAP);
    localparam int CNT_W  = $clog2(PARTICLE_CAP + 1);
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + CNT_W;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_LIN_MUL   = 5'd1;
    localparam logic [4:0] S_LIN_WAIT  = 5'd2;
    localparam logic [4:0] S_LIN_ACC   = 5'd3;
    localparam logic [4:0] S_TRIG_GO   = 5'd4;
    localparam logic [4:0] S_TRIG_WAIT = 5'd5;
    localparam logic [4:0] S_TRIG_MC   = 5'd6;
    localparam logic [4:0] S_TRIG_MS   = 5'd7;
    localparam logic [4:0] S_TRIG_ACC  = 5'd8;
    localparam logic [4:0] S_CHECK     = 5'd9;
    localparam logic [4:0] S_ATW_GO    = 5'd10;
    localparam logic [4:0] S_ATW_WAIT  = 5'd11;
    localparam logic [4:0] S_ATP_GO    = 5'd12;
    localparam logic [4:0] S_ATP_WAIT  = 5'd13;
    localparam logic [4:0] S_DIV_GO    = 5'd14;
    localparam logic [4:0] S_DIV_WAIT  = 5'd15;
    localparam logic [4:0] S_NEXT      = 5'd16;
    localparam logic [4:0] S_COV_SETUP = 5'd17;
    localparam logic [4:0] S_COV_ACC   = 5'd18;
    localparam logic [4:0] S_COV_DIV   = 5'd19;
    localparam logic [4:0] S_EMIT      = 5'd20;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RESULTS - 1);
    localparam logic [2:0]       LAST_C   = 3'(NUM_MEANS - 1);
    localparam logic [VAL_W-1:0] SAT_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

    // Particle memory: one word of six coordinates per particle
    logic [MW-1:0]  r_mem [PARTICLE_CAP];
    logic [MW-1:0]  r_rd;
    logic           mem_we;
    logic [ADDR_W-1:0] rd_addr;

    logic [4:0]     r_state, n_state;
    logic [MW-1:0]  r_word, n_word;
    logic [WGT_W-1:0] r_w, n_w;
    logic           r_last, n_last;
    logic [1:0]     r_c, n_c;
    logic [2:0]     r_i, n_i, r_j, n_j;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_k, n_k, r_count, n_count;
    logic           r_p1, n_p1, r_p2, n_p2, r_p3, n_p3;
    logic signed [MUL_W-1:0]  r_mul_a, n_mul_a, r_mul_b, n_mul_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic           r_ovf, n_ovf;
    logic signed [SUM_W-1:0] r_wlin[NUM_LIN], n_wlin[NUM_LIN];
    logic signed [SUM_W-1:0] r_plin[NUM_LIN], n_plin[NUM_LIN];
    logic signed [SUM_W-1:0] r_wcos[NUM_LIN], n_wcos[NUM_LIN];
    logic signed [SUM_W-1:0] r_wsin[NUM_LIN], n_wsin[NUM_LIN];
    logic signed [SUM_W-1:0] r_pcos[NUM_LIN], n_pcos[NUM_LIN];
    logic signed [SUM_W-1:0] r_psin[NUM_LIN], n_psin[NUM_LIN];
    logic signed [ZW-1:0]    r_wang[NUM_LIN], n_wang[NUM_LIN];
    logic signed [MUL_W-1:0] r_mean[NUM_MEANS], n_mean[NUM_MEANS];
    logic signed [MUL_W-1:0] r_mean_a, n_mean_a, r_mean_b, n_mean_b;
    logic           r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic [VAL_W-1:0] r_out_val, n_out_val;
    logic           r_out_last, n_out_last;

    t_cordic_req           cordic_req;
    t_unit_status          cordic_st, div_st;
    logic signed [CW-1:0]  cordic_x, cordic_y, cos_v, sin_v;
    logic signed [ZW-1:0]  cordic_z, atan_v;
    logic                  div_start;
    logic [ACC_W-1:0]      div_num, div_quot;
    logic [CNT_W-1:0]      div_den;
    logic signed [SUM_W-1:0] plin_c;
    logic [ACC_W-1:0]      acc_mag;
    logic                  in_acc;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign mem_we        = in_acc && (r_count < CNT_W'(PARTICLE_CAP));
    assign rd_addr       = r_k[ADDR_W-1:0];
    assign plin_c        = r_plin[r_c];
    assign acc_mag       = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= s_axis_tdata[MW-1:0];
        end
        r_rd <= r_mem[rd_addr];
    end

    // Shared unit requests
    always_comb begin
        cordic_req.start  = (r_state == S_TRIG_GO) || (r_state == S_ATW_GO) ||
                            (r_state == S_ATP_GO);
        cordic_req.vector = (r_state != S_TRIG_GO);
        if (r_state == S_ATW_GO) begin
            cordic_x = CW'(r_wcos[r_c]);
            cordic_y = CW'(r_wsin[r_c]);
        end else begin
            cordic_x = CW'(r_pcos[r_c]);
            cordic_y = CW'(r_psin[r_c]);
        end
        cordic_z = ZW'(psu_coord(r_word, C_ROLL + 3'(r_c)));
        div_start = 1'b0;
        div_num   = acc_mag;
        div_den   = r_count - 1'b1;
        if (r_state == S_DIV_GO && r_count >= CNT_W'(2)) begin
            div_start = 1'b1;
            div_num   = plin_c[SUM_W-1] ? ACC_W'(-plin_c) : ACC_W'(plin_c);
            div_den   = r_count;
        end else if (r_state == S_COV_ACC && r_k == r_count && !r_p1 && !r_p2 && !r_p3) begin
            div_start = 1'b1;
        end
    end

    psu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (cordic_req),
        .i_x      (cordic_x),
        .i_y      (cordic_y),
        .i_z      (cordic_z),
        .o_status (cordic_st),
        .o_x      (cos_v),
        .o_y      (sin_v),
        .o_z      (atan_v)
    );

    psu_divider #(.NUM_W(ACC_W), .DEN_W(CNT_W)) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_status (div_st),
        .o_quot   (div_quot)
    );

    always_comb begin
        n_state = r_state; n_word = r_word; n_w = r_w; n_last = r_last;
        n_c = r_c; n_i = r_i; n_j = r_j; n_idx = r_idx; n_k = r_k;
        n_count = r_count; n_ovf = r_ovf;
        n_p1 = 1'b0; n_p2 = r_p1; n_p3 = r_p2;
        n_mul_a = r_mul_a; n_mul_b = r_mul_b; n_acc = r_acc;
        n_wlin = r_wlin; n_plin = r_plin; n_wcos = r_wcos; n_wsin = r_wsin;
        n_pcos = r_pcos; n_psin = r_psin; n_wang = r_wang; n_mean = r_mean;
        n_mean_a = r_mean_a; n_mean_b = r_mean_b;
        n_out_valid = r_out_valid; n_out_idx = r_out_idx;
        n_out_val = r_out_val; n_out_last = r_out_last;

        // Covariance pipeline: read, difference, multiply, accumulate
        if (r_p1) begin
            n_mul_a = psu_coord(r_rd, r_i) - r_mean_a;
            n_mul_b = psu_coord(r_rd, r_j) - r_mean_b;
        end
        if (r_p3) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_word = s_axis_tdata[MW-1:0];
                    n_w    = s_axis_tdata[IN_W-1:MW];
                    n_last = s_axis_tlast;
                    n_c    = '0;
                    if (mem_we) begin
                        n_count = r_count + 1'b1;
                        n_state = S_LIN_MUL;
                    end else begin
                        // set is full: drop the particle
                        n_ovf   = 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            S_LIN_MUL: begin
                n_mul_a = psu_coord(r_word, 3'(r_c));
                n_mul_b = MUL_W'(r_w);
                n_state = S_LIN_WAIT;
            end
            S_LIN_WAIT: n_state = S_LIN_ACC;
            S_LIN_ACC: begin
                n_wlin[r_c] = r_wlin[r_c] + SUM_W'(r_prod);
                n_plin[r_c] = r_plin[r_c] + SUM_W'(psu_coord(r_word, 3'(r_c)));
                n_c = r_c + 1'b1;
                if (r_c == 2'(NUM_LIN - 1)) begin
                    n_c     = '0;
                    n_state = S_TRIG_GO;
                end else begin
                    n_state = S_LIN_MUL;
                end
            end
            S_TRIG_GO: n_state = S_TRIG_WAIT;
            S_TRIG_WAIT: begin
                if (cordic_st.done) begin
                    n_mul_a = MUL_W'(cos_v);
                    n_mul_b = MUL_W'(r_w);
                    n_state = S_TRIG_MC;
                end
            end
            S_TRIG_MC: begin
                n_mul_a = MUL_W'(sin_v);
                n_state = S_TRIG_MS;
            end
            S_TRIG_MS: begin
                n_wcos[r_c] = r_wcos[r_c] + SUM_W'(r_prod);
                n_state     = S_TRIG_ACC;
            end
            S_TRIG_ACC: begin
                n_wsin[r_c] = r_wsin[r_c] + SUM_W'(r_prod);
                n_pcos[r_c] = r_pcos[r_c] + SUM_W'(cos_v);
                n_psin[r_c] = r_psin[r_c] + SUM_W'(sin_v);
                n_c = r_c + 1'b1;
                if (r_c == 2'(NUM_LIN - 1)) begin
                    n_c     = '0;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_TRIG_GO;
                end
            end
            S_CHECK: begin
                n_c     = '0;
                n_state = r_last ? S_ATW_GO : S_IDLE;
            end
            S_ATW_GO: n_state = S_ATW_WAIT;
            S_ATW_WAIT: begin
                if (cordic_st.done) begin
                    n_wang[r_c] = atan_v;
                    n_state     = S_ATP_GO;
                end
            end
            S_ATP_GO: n_state = S_ATP_WAIT;
            S_ATP_WAIT: begin
                if (cordic_st.done) begin
                    n_mean[3'(NUM_LIN) + 3'(r_c)] = MUL_W'(atan_v);
                    n_c = r_c + 1'b1;
                    if (r_c == 2'(NUM_LIN - 1)) begin
                        n_c     = '0;
                        n_state = S_DIV_GO;
                    end else begin
                        n_state = S_ATW_GO;
                    end
                end
            end
            S_DIV_GO: begin
                if (r_count >= CNT_W'(2)) begin
                    n_state = S_DIV_WAIT;
                end else begin
                    n_idx = '0; n_i = '0; n_j = '0;
                    n_state = S_NEXT;
                end
            end
            S_DIV_WAIT: begin
                if (div_st.done) begin
                    n_mean[3'(r_c)] = plin_c[SUM_W-1] ? -MUL_W'(div_quot) : MUL_W'(div_quot);
                    n_c = r_c + 1'b1;
                    if (r_c == 2'(NUM_LIN - 1)) begin
                        n_c = '0; n_idx = '0; n_i = '0; n_j = '0;
                        n_state = S_NEXT;
                    end else begin
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_NEXT: begin
                n_out_idx  = r_idx;
                n_out_last = (r_idx == LAST_IDX);
                if (r_idx < IDX_W'(NUM_LIN)) begin
                    n_out_val   = r_wlin[r_idx[1:0]];
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end else if (r_idx < IDX_W'(NUM_MEANS)) begin
                    n_out_val   = {{(VAL_W-16-ZW){r_wang[2'(r_idx - IDX_W'(NUM_LIN))][ZW-1]}},
                                   r_wang[2'(r_idx - IDX_W'(NUM_LIN))], 16'h0000};
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end else if (r_count < CNT_W'(2)) begin
                    n_out_val   = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    n_mean_a = r_mean[r_i];
                    n_state  = S_COV_SETUP;
                end
            end
            S_COV_SETUP: begin
                n_mean_b = r_mean[r_j];
                n_k      = '0;
                n_acc    = '0;
                n_state  = S_COV_ACC;
            end
            S_COV_ACC: begin
                if (r_k != r_count) begin
                    n_k  = r_k + 1'b1;
                    n_p1 = 1'b1;
                end else if (div_start) begin
                    n_state = S_COV_DIV;
                end
            end
            S_COV_DIV: begin
                if (div_st.done) begin
                    if (!r_acc[ACC_W-1]) begin
                        n_out_val = (div_quot[ACC_W-1:VAL_W-1] != '0) ? SAT_MAX
                                                                     : div_quot[VAL_W-1:0];
                    end else if (div_quot[ACC_W-1:VAL_W] != '0 ||
                                 (div_quot[VAL_W-1] && div_quot[VAL_W-2:0] != '0)) begin
                        n_out_val = SAT_MIN;
                    end else begin
                        n_out_val = -div_quot[VAL_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        // set finished: clear sums for the next one
                        for (int c = 0; c < NUM_LIN; c++) begin
                            n_wlin[c] = '0; n_plin[c] = '0; n_wcos[c] = '0;
                            n_wsin[c] = '0; n_pcos[c] = '0; n_psin[c] = '0;
                        end
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        if (r_idx >= IDX_W'(NUM_MEANS)) begin
                            if (r_j == LAST_C) begin
                                n_j = '0;
                                n_i = r_i + 1'b1;
                            end else begin
                                n_j = r_j + 1'b1;
                            end
                        end
                        n_state = S_NEXT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_p1 <= 1'b0; r_p2 <= 1'b0; r_p3 <= 1'b0;
            for (int c = 0; c < NUM_LIN; c++) begin
                r_wlin[c] <= '0; r_plin[c] <= '0; r_wcos[c] <= '0;
                r_wsin[c] <= '0; r_pcos[c] <= '0; r_psin[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_p1 <= n_p1; r_p2 <= n_p2; r_p3 <= n_p3;
            r_wlin <= n_wlin; r_plin <= n_plin; r_wcos <= n_wcos;
            r_wsin <= n_wsin; r_pcos <= n_pcos; r_psin <= n_psin;
        end
        r_word <= n_word; r_w <= n_w; r_last <= n_last;
        r_c <= n_c; r_i <= n_i; r_j <= n_j; r_idx <= n_idx; r_k <= n_k;
        r_mul_a <= n_mul_a; r_mul_b <= n_mul_b;
        r_prod  <= r_mul_a * r_mul_b;
        r_acc   <= n_acc;
        r_wang  <= n_wang; r_mean <= n_mean;
        r_mean_a <= n_mean_a; r_mean_b <= n_mean_b;
        r_out_idx <= n_out_idx; r_out_val <= n_out_val; r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'({r_out_val, r_out_idx});
    assign m_axis_tuser  = r_ovf;
    assign m_axis_tlast  = r_out_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result word is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PARTICLE_CAP))
        else $error("particle count beyond capacity");

    a_clear_after_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (r_count == '0 && !r_ovf))
        else $error("set state not cleared after the last result");

    a_cordic_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_req.start |-> !cordic_st.busy)
        else $error("CORDIC started while busy");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

endmodule

/* dv/particle_pose_statistics_unit_tb.sv */
// Self-checking testbench for particle_pose_statistics_unit: streams particle sets and
// checks all 42 result words against an in-bench fixed-point model.
// Depends on psu_pkg and the design sources only.
module particle_pose_statistics_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psu_pkg::*;

    localparam int CAPACITY = PARTICLE_CAP_DEF;
    localparam int STEPS    = CORDIC_STEPS_DEF;

    typedef struct {
        logic signed [LIN_W-1:0] x, y, z;
        logic signed [ANG_W-1:0] roll, pitch, yaw;
        logic [WGT_W-1:0]        w;
        logic                    last;
    } t_particle;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             ovf;
        logic             last;
    } t_pose_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle, weight, zero pad
    logic [IN_TW-1:0]    s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;    // final_particle
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // result_index, result_value, zero pad
    logic [OUT_TW-1:0]   m_axis_tdata;
    logic                m_axis_tuser;           // capacity_exceeded
    logic                m_axis_tlast;           // final_result

    particle_pose_statistics_unit uut (.*);

    always #5 i_clk = ~i_clk;

    t_particle  pending_particles[$];
    t_pose_word expected_pose_words[$];
    int         error_count = 0;

    // Model state of the current set
    longint     coord_mem[6][CAPACITY];
    longint     wsum[9];
    longint     psum[9];
    int         set_count = 0;
    bit         set_overflow = 0;

    function automatic longint psu_arctan_val(input int i);
        longint tbl[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? tbl[i] : 0;
    endfunction

    function automatic void cordic_sincos(input longint a, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit neg;
        x = CORDIC_GAIN; y = 0; z = a; neg = 0;
        if (z > Q_HALF_PI) begin
            z -= Q_PI; neg = 1;
        end else if (z < -Q_HALF_PI) begin
            z += Q_PI; neg = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(psu_arctan_val(i));
            end else begin
                x += dx; y -= dy; z += longint'(psu_arctan_val(i));
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint cordic_atan2(input longint yi, input longint xi);
        longint x, y, z, t, dx, dy;
        x = xi; y = yi; z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = Q_HALF_PI;
            end else begin
                t = x; x = -y; y = t; z = -Q_HALF_PI;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += psu_arctan_val(i);
            end else begin
                x -= dx; y += dy; z -= psu_arctan_val(i);
            end
        end
        return z;
    endfunction

    // Fold one accepted particle into the set, or flag overflow when full; on the last one queue the 42 words
    task automatic record_particle(input t_particle p);
        longint v[6], s, c, w, mean[6];
        logic signed [127:0] acc, q, dv;
        longint vals[NUM_RESULTS];
        t_pose_word e;
        v[0] = p.x; v[1] = p.y; v[2] = p.z;
        v[3] = p.roll; v[4] = p.pitch; v[5] = p.yaw;
        w = longint'(p.w);
        if (set_count < CAPACITY) begin
            for (int k = 0; k < 6; k++) coord_mem[k][set_count] = v[k];
            for (int k = 0; k < 3; k++) begin
                wsum[k] += v[k] * w;
                psum[k] += v[k];
                cordic_sincos(v[3+k], s, c);
                wsum[3+2*k] += c * w;
                wsum[4+2*k] += s * w;
                psum[3+2*k] += c;
                psum[4+2*k] += s;
            end
            set_count++;
        end else begin
            set_overflow = 1;
        end
        if (!p.last) return;
        for (int k = 0; k < 3; k++) begin
            vals[k]   = wsum[k];
            vals[3+k] = cordic_atan2(wsum[4+2*k], wsum[3+2*k]) * 65536;
        end
        if (set_count < 2) begin
            for (int i = 6; i < NUM_RESULTS; i++) vals[i] = 0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                mean[k]   = psum[k] / longint'(set_count);
                mean[3+k] = cordic_atan2(psum[4+2*k], psum[3+2*k]);
            end
            dv = 128'(set_count - 1);
            for (int i = 0; i < 6; i++) begin
                for (int j = 0; j < 6; j++) begin
                    acc = 0;
                    for (int k = 0; k < set_count; k++)
                        acc += 128'(coord_mem[i][k] - mean[i]) * 128'(coord_mem[j][k] - mean[j]);
                    q = acc / dv;
                    // saturate to the signed 64 bit range
                    if (q > 128'sh7FFF_FFFF_FFFF_FFFF) vals[6+i*6+j] = 64'sh7FFF_FFFF_FFFF_FFFF;
                    else if (q < -128'sh8000_0000_0000_0000) vals[6+i*6+j] = 64'sh8000_0000_0000_0000;
                    else vals[6+i*6+j] = q[63:0];
                end
            end
        end
        for (int i = 0; i < NUM_RESULTS; i++) begin
            e.idx = IDX_W'(i); e.value = vals[i]; e.ovf = set_overflow;
            e.last = (i == NUM_RESULTS - 1);
            expected_pose_words = {expected_pose_words, e};
        end
        for (int k = 0; k < 9; k++) begin
            wsum[k] = 0; psum[k] = 0;
        end
        set_count = 0;
        set_overflow = 0;
    endtask

    // Driver: one word in flight, random gaps between words except in back-to-back blocks
    t_particle cur_particle;
    int        send_gap = 0;
    int        sent_words = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                record_particle(cur_particle);
                sent_words++;
                // every other block of 64 words runs back to back
                send_gap = sent_words[6] ? 0 : $urandom_range(0, 9);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_particles.size() > 0) begin
                    cur_particle = pending_particles.pop_front();
                    s_axis_tdata <= IN_TW'({cur_particle.w, cur_particle.yaw,
                                            cur_particle.pitch, cur_particle.roll,
                                            cur_particle.z, cur_particle.y, cur_particle.x});
                    s_axis_tlast <= cur_particle.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random ready gaps, plus one long hold-off
    int recv_gap = 0;
    int hold_off = 0;
    int recv_words = 0;
    bit held_once = 0;
    always @(posedge i_clk) begin
        t_pose_word e;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                recv_words++;
                if (expected_pose_words.size() == 0) begin
                    $error("unexpected result word idx=%0d", m_axis_tdata[IDX_W-1:0]);
                    error_count++;
                end else begin
                    e = expected_pose_words.pop_front();
                    if (m_axis_tdata[IDX_W-1:0] !== e.idx) begin
                        $error("result_index exp %0d got %0d", e.idx, m_axis_tdata[IDX_W-1:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[IDX_W+VAL_W-1:IDX_W] !== e.value) begin
                        $error("result_value idx %0d exp %h got %h", e.idx, e.value,
                               m_axis_tdata[IDX_W+VAL_W-1:IDX_W]);
                        error_count++;
                    end
                    if (m_axis_tuser !== e.ovf) begin
                        $error("capacity_exceeded exp %0b got %0b", e.ovf, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("final_result exp %0b got %0b", e.last, m_axis_tlast);
                        error_count++;
                    end
                end
                recv_gap = recv_words[7] ? 0 : $urandom_range(0, 9);
                if (recv_words == 50 && !held_once) begin
                    hold_off = 3000;
                    held_once = 1;
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0 && !(m_axis_tvalid && m_axis_tready)) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready && recv_gap > 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void queue_particle(input t_particle p);
        pending_particles = {pending_particles, p};
    endfunction

    function automatic logic signed [LIN_W-1:0] rand_lin();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 2000)) - 1000;
            2:       return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic t_particle rand_particle(input logic last);
        t_particle p;
        p.x = rand_lin(); p.y = rand_lin(); p.z = rand_lin();
        p.roll  = ANG_W'($signed($urandom_range(0, 2 * Q_PI)) - Q_PI);
        p.pitch = ANG_W'($signed($urandom_range(0, 2 * Q_PI)) - Q_PI);
        p.yaw   = ANG_W'($signed($urandom_range(0, 2 * Q_PI)) - Q_PI);
        p.w     = $urandom_range(0, 3) == 0 ? WGT_W'($urandom_range(0, 65536))
                                            : WGT_W'($urandom_range(0, 65536 / 8));
        p.last  = last;
        return p;
    endfunction

    function automatic t_particle mk(input longint x, y, z, r, pt, yw, w, input logic last);
        t_particle p;
        p.x = LIN_W'(x); p.y = LIN_W'(y); p.z = LIN_W'(z);
        p.roll = ANG_W'(r); p.pitch = ANG_W'(pt); p.yaw = ANG_W'(yw);
        p.w = WGT_W'(w); p.last = last;
        return p;
    endfunction

    initial begin
        int n;
        bit big_done;
        big_done = 0;
        for (int k = 0; k < 9; k++) begin
            wsum[k] = 0; psum[k] = 0;
        end
        // single particle at the extremes: covariance all zero
        queue_particle(mk(32'sh7FFF_FFFF, -32'sh8000_0000, 0, Q_PI, -Q_PI, 0, 65536, 1));
        // zero weights: weighted sine and cosine sums vanish
        queue_particle(mk(5, -7, 9, 100, -100, 0, 0, 0));
        queue_particle(mk(-5, 7, -9, Q_HALF_PI, -Q_HALF_PI, Q_HALF_PI + 1, 0, 1));
        // full-scale spread, angles on either side of the half-pi fold
        queue_particle(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000,
                          Q_HALF_PI + 1, -Q_HALF_PI - 1, Q_PI, 65536, 0));
        queue_particle(mk(-32'sh8000_0000, -32'sh8000_0000, 32'sh7FFF_FFFF,
                          -Q_HALF_PI, Q_HALF_PI, -Q_PI, 1, 0));
        queue_particle(mk(0, 1, -1, 0, 1, -1, 32768, 1));
        // left half-plane means in both quadrants
        queue_particle(mk(100, 200, 300, Q_PI - 10, -Q_PI + 10, Q_PI, 30000, 0));
        queue_particle(mk(-100, 0, 300, Q_PI - 1000, -Q_PI + 1000, -Q_PI, 35536, 1));
        // random sets, one of them past capacity
        while (pending_particles.size() < 500) begin
            if (!big_done && pending_particles.size() > 150) begin
                n = CAPACITY + 3;
                big_done = 1;
            end else begin
                n = $urandom_range(1, 12);
            end
            for (int i = 0; i < n; i++) queue_particle(rand_particle(i == n - 1));
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_particles.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        wait (expected_pose_words.size() == 0);
        repeat (200) @(posedge i_clk);
        if (expected_pose_words.size() != 0) begin
            $error("%0d result words never arrived", expected_pose_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
